// ===== rtl/core/sct_pkg.sv =====
// Shared types for the segment crossing pipeline.
package sct_pkg;

  typedef struct packed {
    logic neg;
    logic zero;
  } sct_sign_t;

endpackage

// ===== rtl/core/sct_diff.sv =====
// Stage 1: coordinate differences and the collinear x-projection overlap flag.
module sct_diff #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic signed [COORD_BITS-1:0] dx_i,
  input  logic signed [COORD_BITS-1:0] dy_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [COORD_BITS:0]   cax_o,
  output logic signed [COORD_BITS:0]   cay_o,
  output logic signed [COORD_BITS:0]   dax_o,
  output logic signed [COORD_BITS:0]   day_o,
  output logic signed [COORD_BITS:0]   abx_o,
  output logic signed [COORD_BITS:0]   aby_o,
  output logic signed [COORD_BITS:0]   acx_o,
  output logic signed [COORD_BITS:0]   acy_o,
  output logic signed [COORD_BITS:0]   bcx_o,
  output logic signed [COORD_BITS:0]   bcy_o,
  output logic signed [COORD_BITS:0]   dcx_o,
  output logic signed [COORD_BITS:0]   dcy_o,
  output logic                         overlap_o
);

  localparam int unsigned DW = COORD_BITS + 1;

  logic signed [DW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic signed [DW-1:0] cax_d, cay_d, dax_d, day_d, abx_d, aby_d;
  logic signed [DW-1:0] acx_d, acy_d, bcx_d, bcy_d, dcx_d, dcy_d;
  logic signed [DW-1:0] cax_q, cay_q, dax_q, day_q, abx_q, aby_q;
  logic signed [DW-1:0] acx_q, acy_q, bcx_q, bcy_q, dcx_q, dcy_q;
  logic                 overlap_d, overlap_q;
  logic                 valid_q;

  assign ax = DW'(ax_i);
  assign ay = DW'(ay_i);
  assign bx = DW'(bx_i);
  assign by = DW'(by_i);
  assign cx = DW'(cx_i);
  assign cy = DW'(cy_i);
  assign dx = DW'(dx_i);
  assign dy = DW'(dy_i);

  assign cax_d = cx - ax;
  assign cay_d = cy - ay;
  assign dax_d = dx - ax;
  assign day_d = dy - ay;
  assign abx_d = bx - ax;
  assign aby_d = by - ay;
  assign acx_d = ax - cx;
  assign acy_d = ay - cy;
  assign bcx_d = bx - cx;
  assign bcy_d = by - cy;
  assign dcx_d = dx - cx;
  assign dcy_d = dy - cy;

  assign overlap_d = ((ax_i <= cx_i) && (cx_i < bx_i))
                  || ((cx_i <= ax_i) && (ax_i < dx_i))
                  || ((cx_i <= ax_i) && (bx_i <= dx_i))
                  || ((ax_i <= cx_i) && (dx_i <= bx_i));

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cax_q     <= cax_d;
      cay_q     <= cay_d;
      dax_q     <= dax_d;
      day_q     <= day_d;
      abx_q     <= abx_d;
      aby_q     <= aby_d;
      acx_q     <= acx_d;
      acy_q     <= acy_d;
      bcx_q     <= bcx_d;
      bcy_q     <= bcy_d;
      dcx_q     <= dcx_d;
      dcy_q     <= dcy_d;
      overlap_q <= overlap_d;
    end
  end

  assign valid_o   = valid_q;
  assign cax_o     = cax_q;
  assign cay_o     = cay_q;
  assign dax_o     = dax_q;
  assign day_o     = day_q;
  assign abx_o     = abx_q;
  assign aby_o     = aby_q;
  assign acx_o     = acx_q;
  assign acy_o     = acy_q;
  assign bcx_o     = bcx_q;
  assign bcy_o     = bcy_q;
  assign dcx_o     = dcx_q;
  assign dcy_o     = dcy_q;
  assign overlap_o = overlap_q;

endmodule

// ===== rtl/core/sct_mul.sv =====
// Stage 2: the eight cross-product terms, one multiplier each.
module sct_mul #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [COORD_BITS:0]         cax_i,
  input  logic signed [COORD_BITS:0]         cay_i,
  input  logic signed [COORD_BITS:0]         dax_i,
  input  logic signed [COORD_BITS:0]         day_i,
  input  logic signed [COORD_BITS:0]         abx_i,
  input  logic signed [COORD_BITS:0]         aby_i,
  input  logic signed [COORD_BITS:0]         acx_i,
  input  logic signed [COORD_BITS:0]         acy_i,
  input  logic signed [COORD_BITS:0]         bcx_i,
  input  logic signed [COORD_BITS:0]         bcy_i,
  input  logic signed [COORD_BITS:0]         dcx_i,
  input  logic signed [COORD_BITS:0]         dcy_i,
  input  logic                               overlap_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [2*COORD_BITS+1:0]     p1_o,
  output logic signed [2*COORD_BITS+1:0]     q1_o,
  output logic signed [2*COORD_BITS+1:0]     p2_o,
  output logic signed [2*COORD_BITS+1:0]     q2_o,
  output logic signed [2*COORD_BITS+1:0]     p3_o,
  output logic signed [2*COORD_BITS+1:0]     q3_o,
  output logic signed [2*COORD_BITS+1:0]     p4_o,
  output logic signed [2*COORD_BITS+1:0]     q4_o,
  output logic                               overlap_o
);

  localparam int unsigned PW = 2 * (COORD_BITS + 1);

  logic signed [PW-1:0] p1_d, q1_d, p2_d, q2_d, p3_d, q3_d, p4_d, q4_d;
  logic signed [PW-1:0] p1_q, q1_q, p2_q, q2_q, p3_q, q3_q, p4_q, q4_q;
  logic                 overlap_q;
  logic                 valid_q;

  assign p1_d = PW'(cax_i) * PW'(aby_i);
  assign q1_d = PW'(cay_i) * PW'(abx_i);
  assign p2_d = PW'(dax_i) * PW'(aby_i);
  assign q2_d = PW'(day_i) * PW'(abx_i);
  assign p3_d = PW'(acx_i) * PW'(dcy_i);
  assign q3_d = PW'(acy_i) * PW'(dcx_i);
  assign p4_d = PW'(bcx_i) * PW'(dcy_i);
  assign q4_d = PW'(bcy_i) * PW'(dcx_i);

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      p1_q      <= p1_d;
      q1_q      <= q1_d;
      p2_q      <= p2_d;
      q2_q      <= q2_d;
      p3_q      <= p3_d;
      q3_q      <= q3_d;
      p4_q      <= p4_d;
      q4_q      <= q4_d;
      overlap_q <= overlap_i;
    end
  end

  assign valid_o   = valid_q;
  assign p1_o      = p1_q;
  assign q1_o      = q1_q;
  assign p2_o      = p2_q;
  assign q2_o      = q2_q;
  assign p3_o      = p3_q;
  assign q3_o      = q3_q;
  assign p4_o      = p4_q;
  assign q4_o      = q4_q;
  assign overlap_o = overlap_q;

endmodule

// ===== rtl/core/sct_sign.sv =====
// Stage 3: compare product pairs into orientation signs.
module sct_sign #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [2*COORD_BITS+1:0] p1_i,
  input  logic signed [2*COORD_BITS+1:0] q1_i,
  input  logic signed [2*COORD_BITS+1:0] p2_i,
  input  logic signed [2*COORD_BITS+1:0] q2_i,
  input  logic signed [2*COORD_BITS+1:0] p3_i,
  input  logic signed [2*COORD_BITS+1:0] q3_i,
  input  logic signed [2*COORD_BITS+1:0] p4_i,
  input  logic signed [2*COORD_BITS+1:0] q4_i,
  input  logic                           overlap_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output sct_pkg::sct_sign_t             s1_o,
  output sct_pkg::sct_sign_t             s2_o,
  output sct_pkg::sct_sign_t             s3_o,
  output sct_pkg::sct_sign_t             s4_o,
  output logic                           overlap_o
);

  import sct_pkg::*;

  sct_sign_t s1_d, s2_d, s3_d, s4_d;
  sct_sign_t s1_q, s2_q, s3_q, s4_q;
  logic      overlap_q;
  logic      valid_q;

  assign s1_d = '{neg: (p1_i < q1_i), zero: (p1_i == q1_i)};
  assign s2_d = '{neg: (p2_i < q2_i), zero: (p2_i == q2_i)};
  assign s3_d = '{neg: (p3_i < q3_i), zero: (p3_i == q3_i)};
  assign s4_d = '{neg: (p4_i < q4_i), zero: (p4_i == q4_i)};

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      s3_q      <= s3_d;
      s4_q      <= s4_d;
      overlap_q <= overlap_i;
    end
  end

  assign valid_o   = valid_q;
  assign s1_o      = s1_q;
  assign s2_o      = s2_q;
  assign s3_o      = s3_q;
  assign s4_o      = s4_q;
  assign overlap_o = overlap_q;

endmodule

// ===== rtl/core/sct_decide.sv =====
// Stage 4: combine orientation signs into the crossing verdict; output register.
module sct_decide (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  sct_pkg::sct_sign_t s1_i,
  input  sct_pkg::sct_sign_t s2_i,
  input  sct_pkg::sct_sign_t s3_i,
  input  sct_pkg::sct_sign_t s4_i,
  input  logic               overlap_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic               crosses_o
);

  import sct_pkg::*;

  logic crosses_d, crosses_q;
  logic valid_q;

  always_comb begin
    if (s1_i.zero && s2_i.zero) begin
      crosses_d = overlap_i;
    end else if (s1_i.zero || s2_i.zero || (s1_i.neg == s2_i.neg)) begin
      crosses_d = 1'b0;
    end else begin
      crosses_d = (s3_i != s4_i);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      crosses_q <= crosses_d;
    end
  end

  assign valid_o   = valid_q;
  assign crosses_o = crosses_q;

endmodule

// ===== rtl/core/segment_crossing_test_top.sv =====
// Segment crossing test: four-stage pipeline, differences, products, signs, verdict.
// Four register stages, differences, products, signs and verdict, lie between request acceptance and the result.
// Throughput: one request per cycle while the output is not stalled; the multiplier stage sets the clock.
// Each stage holds its item while the next one stalls and takes a new one once empty.
// Reset clears all stage valid bits asynchronously; payload registers are not reset.
module segment_crossing_test_top #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] first_start_x_i,
  input  logic signed [COORD_BITS-1:0] first_start_y_i,
  input  logic signed [COORD_BITS-1:0] first_end_x_i,
  input  logic signed [COORD_BITS-1:0] first_end_y_i,
  input  logic signed [COORD_BITS-1:0] second_start_x_i,
  input  logic signed [COORD_BITS-1:0] second_start_y_i,
  input  logic signed [COORD_BITS-1:0] second_end_x_i,
  input  logic signed [COORD_BITS-1:0] second_end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         crosses_o
);

  import sct_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  logic                 d_valid, d_ready;
  logic signed [DW-1:0] cax, cay, dax, day, abx, aby;
  logic signed [DW-1:0] acx, acy, bcx, bcy, dcx, dcy;
  logic                 d_overlap;

  logic                 m_valid, m_ready;
  logic signed [PW-1:0] p1, q1, p2, q2, p3, q3, p4, q4;
  logic                 m_overlap;

  logic                 s_valid, s_ready;
  sct_sign_t            s1, s2, s3, s4;
  logic                 s_overlap;

  sct_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .ax_i      (first_start_x_i),
    .ay_i      (first_start_y_i),
    .bx_i      (first_end_x_i),
    .by_i      (first_end_y_i),
    .cx_i      (second_start_x_i),
    .cy_i      (second_start_y_i),
    .dx_i      (second_end_x_i),
    .dy_i      (second_end_y_i),
    .valid_o   (d_valid),
    .ready_i   (d_ready),
    .cax_o     (cax),
    .cay_o     (cay),
    .dax_o     (dax),
    .day_o     (day),
    .abx_o     (abx),
    .aby_o     (aby),
    .acx_o     (acx),
    .acy_o     (acy),
    .bcx_o     (bcx),
    .bcy_o     (bcy),
    .dcx_o     (dcx),
    .dcy_o     (dcy),
    .overlap_o (d_overlap)
  );

  sct_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (d_valid),
    .ready_o   (d_ready),
    .cax_i     (cax),
    .cay_i     (cay),
    .dax_i     (dax),
    .day_i     (day),
    .abx_i     (abx),
    .aby_i     (aby),
    .acx_i     (acx),
    .acy_i     (acy),
    .bcx_i     (bcx),
    .bcy_i     (bcy),
    .dcx_i     (dcx),
    .dcy_i     (dcy),
    .overlap_i (d_overlap),
    .valid_o   (m_valid),
    .ready_i   (m_ready),
    .p1_o      (p1),
    .q1_o      (q1),
    .p2_o      (p2),
    .q2_o      (q2),
    .p3_o      (p3),
    .q3_o      (q3),
    .p4_o      (p4),
    .q4_o      (q4),
    .overlap_o (m_overlap)
  );

  sct_sign #(.COORD_BITS(COORD_BITS)) u_sign (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (m_valid),
    .ready_o   (m_ready),
    .p1_i      (p1),
    .q1_i      (q1),
    .p2_i      (p2),
    .q2_i      (q2),
    .p3_i      (p3),
    .q3_i      (q3),
    .p4_i      (p4),
    .q4_i      (q4),
    .overlap_i (m_overlap),
    .valid_o   (s_valid),
    .ready_i   (s_ready),
    .s1_o      (s1),
    .s2_o      (s2),
    .s3_o      (s3),
    .s4_o      (s4),
    .overlap_o (s_overlap)
  );

  sct_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_valid),
    .ready_o   (s_ready),
    .s1_i      (s1),
    .s2_i      (s2),
    .s3_i      (s3),
    .s4_i      (s4),
    .overlap_i (s_overlap),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .crosses_o (crosses_o)
  );

endmodule

// ===== dv/tb_segment_crossing_test_top.sv =====
// Testbench for segment_crossing_test_top: directed and random pairs against a predictor.
module tb_segment_crossing_test_top;

  localparam int unsigned COORD_BITS = 31;
  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_BITS - 1));
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam int RANDOM_REQUESTS = 1780;
  localparam int PAUSE_AT = 600;
  localparam int HOLD_AT = 1400;
  localparam int HOLD_CYCLES = 100;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;

  // Points in order: A.x, A.y, B.x, B.y, C.x, C.y, D.x, D.y
  typedef logic [7:0][COORD_BITS-1:0] segment_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic signed [COORD_BITS-1:0] first_start_x_i = '0;
  logic signed [COORD_BITS-1:0] first_start_y_i = '0;
  logic signed [COORD_BITS-1:0] first_end_x_i = '0;
  logic signed [COORD_BITS-1:0] first_end_y_i = '0;
  logic signed [COORD_BITS-1:0] second_start_x_i = '0;
  logic signed [COORD_BITS-1:0] second_start_y_i = '0;
  logic signed [COORD_BITS-1:0] second_end_x_i = '0;
  logic signed [COORD_BITS-1:0] second_end_y_i = '0;
  logic in_ready_o;
  logic out_valid_o;
  logic crosses_o;

  segment_pair_t pending_requests[$];
  bit crossing_verdicts[$];
  segment_pair_t offered;
  bit expected_cross;
  int total_requests = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit pause_done = 1'b0;
  int cycle_count = 0;

  segment_crossing_test_top #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .first_start_x_i (first_start_x_i),
    .first_start_y_i (first_start_y_i),
    .first_end_x_i   (first_end_x_i),
    .first_end_y_i   (first_end_y_i),
    .second_start_x_i(second_start_x_i),
    .second_start_y_i(second_start_y_i),
    .second_end_x_i  (second_end_x_i),
    .second_end_y_i  (second_end_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .crosses_o       (crosses_o)
  );

  function automatic longint coord_value(logic [COORD_BITS-1:0] raw);
    return longint'($signed(raw));
  endfunction

  function automatic int orientation_sign(longint ux, longint uy, longint vx, longint vy);
    longint p;
    longint q;
    p = ux * vy;
    q = uy * vx;
    if (p < q) return -1;
    if (p > q) return 1;
    return 0;
  endfunction

  function automatic bit predict_crossing(segment_pair_t pair);
    longint ax, ay, bx, by, cx, cy, dx, dy;
    int s1, s2, s3, s4;
    ax = coord_value(pair[0]);
    ay = coord_value(pair[1]);
    bx = coord_value(pair[2]);
    by = coord_value(pair[3]);
    cx = coord_value(pair[4]);
    cy = coord_value(pair[5]);
    dx = coord_value(pair[6]);
    dy = coord_value(pair[7]);
    s1 = orientation_sign(cx - ax, cy - ay, bx - ax, by - ay);
    s2 = orientation_sign(dx - ax, dy - ay, bx - ax, by - ay);
    if (s1 == 0 && s2 == 0) begin
      return (ax <= cx && cx < bx) || (cx <= ax && ax < dx) ||
             (cx <= ax && bx <= dx) || (ax <= cx && dx <= bx);
    end
    if (s1 == 0 || s2 == 0 || s1 == s2) return 1'b0;
    s3 = orientation_sign(ax - cx, ay - cy, dx - cx, dy - cy);
    s4 = orientation_sign(bx - cx, by - cy, dx - cx, dy - cy);
    return s3 != s4;
  endfunction

  function automatic segment_pair_t points(longint ax, longint ay, longint bx, longint by,
                                           longint cx, longint cy, longint dx, longint dy);
    segment_pair_t pair;
    pair[0] = ax[COORD_BITS-1:0];
    pair[1] = ay[COORD_BITS-1:0];
    pair[2] = bx[COORD_BITS-1:0];
    pair[3] = by[COORD_BITS-1:0];
    pair[4] = cx[COORD_BITS-1:0];
    pair[5] = cy[COORD_BITS-1:0];
    pair[6] = dx[COORD_BITS-1:0];
    pair[7] = dy[COORD_BITS-1:0];
    return pair;
  endfunction

  function automatic void queue_request(segment_pair_t pair);
    pending_requests.insert(pending_requests.size(), pair);
  endfunction

  function automatic longint rand_span(int unsigned span);
    return longint'($urandom_range(2 * span)) - longint'(span);
  endfunction

  function automatic segment_pair_t random_pair();
    segment_pair_t pair;
    longint base_x, base_y, dir_x, dir_y, step, v;
    int unsigned pick;
    pick = $urandom_range(99);
    base_x = rand_span(1 << 28);
    base_y = rand_span(1 << 28);
    dir_x = rand_span(1000);
    dir_y = rand_span(1000);
    for (int i = 0; i < 8; i++) begin
      pair[i] = COORD_BITS'($urandom);
    end
    if (pick >= 20 && pick < 40) begin
      for (int i = 0; i < 8; i++) begin
        v = ((i % 2) == 0 ? base_x : base_y) + rand_span(1000);
        pair[i] = v[COORD_BITS-1:0];
      end
    end else if (pick >= 40 && pick < 55) begin
      for (int i = 0; i < 8; i++) begin
        v = rand_span(4);
        pair[i] = v[COORD_BITS-1:0];
      end
    end else if (pick >= 55 && pick < 88) begin
      for (int k = 0; k < 4; k++) begin
        step = rand_span(1000);
        v = base_x + step * dir_x;
        pair[2 * k] = v[COORD_BITS-1:0];
        v = base_y + step * dir_y;
        pair[2 * k + 1] = v[COORD_BITS-1:0];
      end
      // move one endpoint of CD off the line
      if (pick >= 75) begin
        step = ($urandom_range(1) == 0) ? 4 : 6;
        v = base_x + rand_span(1000);
        pair[step] = v[COORD_BITS-1:0];
        v = base_y + rand_span(1000);
        pair[step + 1] = v[COORD_BITS-1:0];
      end
    end else if (pick >= 88 && pick < 95) begin
      for (int i = 0; i < 8; i++) begin
        v = ((i % 2) == 0 ? base_x : base_y) + rand_span(20);
        pair[i] = v[COORD_BITS-1:0];
      end
      pair[2] = pair[0];
      pair[3] = pair[1];
    end else if (pick >= 95) begin
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(4))
          0: v = COORD_MIN;
          1: v = COORD_MAX;
          2: v = 0;
          3: v = -1;
          default: v = coord_value(pair[i]);
        endcase
        pair[i] = v[COORD_BITS-1:0];
      end
    end
    return pair;
  endfunction

  function automatic int sender_idle_pct(int sent);
    if (sent < total_requests / 3) return 24;
    if (sent < 2 * total_requests / 3) return 85;
    return 0;
  endfunction

  function automatic int receiver_idle_pct(int seen);
    if (seen < total_requests / 3) return 85;
    if (seen < 2 * total_requests / 3) return 24;
    return 0;
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        crossing_verdicts.insert(crossing_verdicts.size(), predict_crossing(offered));
        requests_sent++;
      end
      if (!pause_done && requests_sent == PAUSE_AT && crossing_verdicts.size() == 0) begin
        pause_done = 1'b1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_requests.size() != 0 && (pause_done || requests_sent != PAUSE_AT) &&
            $urandom_range(99) >= sender_idle_pct(requests_sent)) begin
          offered = pending_requests.pop_front();
          first_start_x_i <= offered[0];
          first_start_y_i <= offered[1];
          first_end_x_i <= offered[2];
          first_end_y_i <= offered[3];
          second_start_x_i <= offered[4];
          second_start_y_i <= offered[5];
          second_end_x_i <= offered[6];
          second_end_y_i <= offered[7];
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (crossing_verdicts.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual crosses=%0b", $time, crosses_o);
          mismatch_count++;
        end else begin
          expected_cross = crossing_verdicts.pop_front();
          if (crosses_o !== expected_cross) begin
            $display("%0t: crosses mismatch, expected %0b, actual %0b", $time, expected_cross,
                     crosses_o);
            mismatch_count++;
          end
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_seen == HOLD_AT) begin
        // hold off the receiver so the pipeline fills and stalls its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= $urandom_range(99) >= receiver_idle_pct(results_seen);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("segment_crossing_test_top verification failed");
      $finish;
    end
  end

  initial begin
    queue_request(points(0, 0, 10, 10, 0, 10, 10, 0));
    queue_request(points(0, 0, 10, 0, 0, 1, 10, 1));
    queue_request(points(0, 0, 10, 0, 5, 0, 15, 0));
    queue_request(points(0, 0, 4, 0, 6, 0, 9, 0));
    queue_request(points(0, 0, 5, 0, 5, 0, 9, 0));
    queue_request(points(10, 0, 0, 0, 2, 0, 5, 0));
    queue_request(points(0, 0, 10, 0, 15, 0, 5, 0));
    queue_request(points(3, 0, 3, 10, 3, 20, 3, 30));
    queue_request(points(2, 2, 2, 2, 0, 0, 5, 9));
    queue_request(points(2, 2, 2, 2, -4, 7, 1, -3));
    queue_request(points(0, 0, 10, 0, 5, 0, 5, 5));
    queue_request(points(0, 0, 10, 0, 5, 5, 5, 0));
    queue_request(points(0, 0, 10, 0, 5, -5, 5, 5));
    queue_request(points(0, 0, 10, 0, 20, -5, 20, 5));
    queue_request(points(0, 0, 10, 10, 5, -5, 12, 1));
    queue_request(points(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    queue_request(points(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                         COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    queue_request(points(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                         COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    queue_request(points(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                         COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    queue_request(points(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                         COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    queue_request(points(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX - 1,
                         COORD_MIN, COORD_MIN + 1, COORD_MAX, COORD_MAX));
    queue_request(points(-1, -1, -1, -1, -1, -1, -1, -1));
    queue_request(points(COORD_MIN, 0, COORD_MAX, -1,
                         0, COORD_MIN, -1, COORD_MAX));
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      queue_request(random_pair());
    end
    total_requests = pending_requests.size();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (requests_sent < total_requests || crossing_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("segment_crossing_test_top verification clean");
    end else begin
      $display("segment_crossing_test_top verification failed");
    end
    $finish;
  end

endmodule
